[hdl/efd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte step for the escaped frame decoder.
// No dependencies; every other file of the block imports this package.
package efd_pkg;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 16;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [BYTE_W-1:0] START_RESET  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
  localparam logic [BYTE_W-1:0] XOR_RESET    = 8'd32;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2,
    REG_XOR    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RO_IDLE,
    RO_READ,
    RO_LOAD,
    RO_STAT
  } ro_state_t;

  // Frame close event from the receiver to the readout side.
  typedef struct packed {
    logic               fire;
    logic               ok;
    logic [IDX_W-1:0]   plen;
    logic [COUNT_W-1:0] count;
  } close_t;

  // One byte of CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] d);
    logic [15:0] c;
    c = crc_in ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/efd_store.sv]
`timescale 1ns / 1ps
// Frame store: single write port, one registered read port.
// Depends on efd_pkg for the byte width.
module efd_store #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [efd_pkg::BYTE_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [efd_pkg::BYTE_W-1:0]   rd_data
);
  import efd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/efd_rx.sv]
`timescale 1ns / 1ps
// Receive side: unstuffs bytes, fills the frame store, runs the CRC and judges frames.
// Depends on efd_pkg (close_t, crc16_byte, constants).
module efd_rx #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic [efd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [efd_pkg::BYTE_W-1:0]   start_byte,
  input  logic [efd_pkg::BYTE_W-1:0]   end_byte,
  input  logic [efd_pkg::BYTE_W-1:0]   escape_byte,
  input  logic [efd_pkg::BYTE_W-1:0]   escape_xor,
  output logic                         wr_en,
  output logic [$clog2(DEPTH)-1:0]     wr_addr,
  output logic [efd_pkg::BYTE_W-1:0]   wr_data,
  output efd_pkg::close_t              close_ev
);
  import efd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
  localparam logic [FW-1:0] TWO_F   = FW'(2);

  logic               in_frame, in_frame_next;
  logic               esc, esc_next;
  logic [FW-1:0]      fill, fill_next;
  logic [15:0]        crc, crc_next;
  logic [BYTE_W-1:0]  tail0, tail0_next;   // second to last stored byte
  logic [BYTE_W-1:0]  tail1, tail1_next;   // last stored byte
  logic [COUNT_W-1:0] bad, bad_next;
  logic [COUNT_W-1:0] bad_inc;
  logic [BYTE_W-1:0]  d;
  logic               short_frame;
  logic               crc_match;

  assign bad_inc     = (bad == COUNT_MAX) ? bad : bad + 1'b1;
  assign d           = esc ? (rx_byte ^ escape_xor) : rx_byte;
  assign short_frame = fill < TWO_F;
  assign crc_match   = crc == {tail0, tail1};
  assign wr_addr     = fill[AW-1:0];
  assign wr_data     = d;

  always_comb begin
    in_frame_next = in_frame;
    esc_next      = esc;
    fill_next     = fill;
    crc_next      = crc;
    tail0_next    = tail0;
    tail1_next    = tail1;
    bad_next      = bad;
    wr_en         = 1'b0;
    close_ev      = '0;
    if (in_fire) begin
      if (rx_byte == start_byte) begin
        in_frame_next = 1'b1;
        esc_next      = 1'b0;
        fill_next     = '0;
        crc_next      = CRC_INIT;
      end else if (in_frame) begin
        if (rx_byte == end_byte && !esc) begin
          in_frame_next = 1'b0;
          close_ev.fire = 1'b1;
          close_ev.ok   = !short_frame && crc_match;
          close_ev.plen = IDX_W'(fill - TWO_F);
          if (short_frame || !crc_match) begin
            bad_next = bad_inc;
          end
          close_ev.count = bad_next;
          if (short_frame || !crc_match) begin
            close_ev.plen = '0;
          end
        end else if (rx_byte == escape_byte && !esc) begin
          esc_next = 1'b1;
        end else begin
          esc_next = 1'b0;
          if (fill < DEPTH_F) begin
            wr_en      = 1'b1;
            fill_next  = fill + 1'b1;
            tail0_next = tail1;
            tail1_next = d;
            // Fold the byte leaving the two-byte tail into the CRC.
            if (!short_frame) begin
              crc_next = crc16_byte(crc, tail0);
            end
          end else begin
            in_frame_next = 1'b0;
            bad_next      = bad_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      esc      <= 1'b0;
      fill     <= '0;
      bad      <= '0;
    end else begin
      in_frame <= in_frame_next;
      esc      <= esc_next;
      fill     <= fill_next;
      bad      <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    crc   <= crc_next;
    tail0 <= tail0_next;
    tail1 <= tail1_next;
  end

endmodule

[hdl/efd_readout.sv]
`timescale 1ns / 1ps
// Readout sequencer: walks the frame store after a good frame and drives the result register.
// Depends on efd_pkg (close_t, ro_state_t, result kinds).
module efd_readout #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  efd_pkg::close_t               close_ev,
  output logic                          take_ok,
  output logic                          rd_en,
  output logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  logic [efd_pkg::BYTE_W-1:0]    rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [efd_pkg::BYTE_W-1:0]    data_byte,
  output logic [efd_pkg::IDX_W-1:0]     byte_index,
  output logic                          frame_ok,
  output logic [efd_pkg::IDX_W-1:0]     payload_length,
  output logic [efd_pkg::COUNT_W-1:0]   invalid_count,
  output logic                          last_of_run
);
  import efd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  ro_state_t          state, state_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [IDX_W-1:0]   plen_q, plen_next;
  logic [COUNT_W-1:0] count_q, count_next;
  logic               out_free;
  logic               load;
  logic               ld_kind, ld_ok, ld_last;
  logic [BYTE_W-1:0]  ld_data;
  logic [IDX_W-1:0]   ld_idx, ld_plen;
  logic [COUNT_W-1:0] ld_count;
  logic [IDX_W-1:0]   idx_inc;

  assign out_free = !out_valid || out_ready;
  assign take_ok  = (state == RO_IDLE) && out_free;
  assign rd_en    = (state == RO_READ);
  assign rd_addr  = rd_idx[AW-1:0];
  assign idx_inc  = rd_idx + 1'b1;

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    plen_next   = plen_q;
    count_next  = count_q;
    load        = 1'b0;
    ld_kind     = KIND_STATUS;
    ld_data     = '0;
    ld_idx      = '0;
    ld_ok       = 1'b0;
    ld_plen     = '0;
    ld_count    = count_q;
    ld_last     = 1'b1;
    unique case (state)
      RO_IDLE: begin
        if (close_ev.fire) begin
          count_next = close_ev.count;
          if (close_ev.ok && close_ev.plen != '0) begin
            plen_next   = close_ev.plen;
            rd_idx_next = '0;
            state_next  = RO_READ;
          end else begin
            // Bad frame or empty payload: status only.
            load     = 1'b1;
            ld_ok    = close_ev.ok;
            ld_count = close_ev.count;
          end
        end
      end
      RO_READ: begin
        state_next = RO_LOAD;
      end
      RO_LOAD: begin
        if (out_free) begin
          load        = 1'b1;
          ld_kind     = KIND_PAYLOAD;
          ld_data     = rd_data;
          ld_idx      = rd_idx;
          ld_last     = 1'b0;
          rd_idx_next = idx_inc;
          state_next  = (idx_inc == plen_q) ? RO_STAT : RO_READ;
        end
      end
      RO_STAT: begin
        if (out_free) begin
          load       = 1'b1;
          ld_ok      = 1'b1;
          ld_plen    = plen_q;
          state_next = RO_IDLE;
        end
      end
      default: state_next = RO_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RO_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    plen_q  <= plen_next;
    count_q <= count_next;
    if (load) begin
      result_kind    <= ld_kind;
      data_byte      <= ld_data;
      byte_index     <= ld_idx;
      frame_ok       <= ld_ok;
      payload_length <= ld_plen;
      invalid_count  <= ld_count;
      last_of_run    <= ld_last;
    end
  end

endmodule

[hdl/escaped_frame_decoder_crc16.sv]
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame decoder with CRC-16 check.
// Depends on efd_pkg, efd_store, efd_rx and efd_readout.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | rx_byte
//  result   | out_valid / out_ready| result_kind, data_byte, byte_index, frame_ok,
//           |                      | payload_length, invalid_count, last_of_run
//  config   | cfg_write            | cfg_index, cfg_data
//
// A received word is taken when the block is idle and the result register
// is free or being drained. A good frame's end word then starts the readout:
// each payload word takes a store read, then a result load once the result
// register is free (the frame store's read port is registered); the status
// word follows, and input is held off until the status word is loaded. Reset clears
// control state and restores the default framing codes; the frame store needs
// no clearing, since only entries written in the current frame are read back.
module escaped_frame_decoder_crc16 #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [efd_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [efd_pkg::BYTE_W-1:0]    data_byte,
  output logic [efd_pkg::IDX_W-1:0]     byte_index,
  output logic                          frame_ok,
  output logic [efd_pkg::IDX_W-1:0]     payload_length,
  output logic [efd_pkg::COUNT_W-1:0]   invalid_count,
  output logic                          last_of_run,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [efd_pkg::BYTE_W-1:0]    cfg_data
);
  import efd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // Framing codes; the user must write them only while the block is idle, which the block does not enforce.
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic [BYTE_W-1:0] escape_byte;
  logic [BYTE_W-1:0] escape_xor;

  logic              in_fire;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  close_t            close_ev;
  logic              take_ok;

  assign in_ready = take_ok;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= START_RESET;
      end_byte    <= END_RESET;
      escape_byte <= ESCAPE_RESET;
      escape_xor  <= XOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START:  start_byte  <= cfg_data;
        REG_END:    end_byte    <= cfg_data;
        REG_ESCAPE: escape_byte <= cfg_data;
        REG_XOR:    escape_xor  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unstuff, store and check incoming words.
  efd_rx #(.DEPTH(STORE_DEPTH)) u_rx (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .rx_byte     (rx_byte),
    .start_byte  (start_byte),
    .end_byte    (end_byte),
    .escape_byte (escape_byte),
    .escape_xor  (escape_xor),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .close_ev    (close_ev)
  );

  // Frame store; writes come only during reception, reads only during readout.
  efd_store #(.DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Walk the payload and drive the result register.
  efd_readout #(.DEPTH(STORE_DEPTH)) u_readout (
    .clk            (clk),
    .rst            (rst),
    .close_ev       (close_ev),
    .take_ok        (take_ok),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .data_byte      (data_byte),
    .byte_index     (byte_index),
    .frame_ok       (frame_ok),
    .payload_length (payload_length),
    .invalid_count  (invalid_count),
    .last_of_run    (last_of_run)
  );

endmodule

[hdl/efd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the frame decoder, bound to the top level.
// Depends on efd_pkg and escaped_frame_decoder_crc16.
module efd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          result_kind,
  input logic [efd_pkg::BYTE_W-1:0]    data_byte,
  input logic [efd_pkg::IDX_W-1:0]     byte_index,
  input logic                          frame_ok,
  input logic [efd_pkg::IDX_W-1:0]     payload_length,
  input logic [efd_pkg::COUNT_W-1:0]   invalid_count,
  input logic                          last_of_run
);
  import efd_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(result_kind))
    else $error("result word changed while stalled");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |->
      !frame_ok && payload_length == '0 && !last_of_run)
    else $error("payload word carries status fields");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS |->
      last_of_run && data_byte == '0 && byte_index == '0 &&
      (frame_ok || payload_length == '0))
    else $error("malformed status word");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(rst) |->
      invalid_count >= $past(invalid_count))
    else $error("invalid frame count went down");

endmodule

bind escaped_frame_decoder_crc16 efd_checker u_efd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .result_kind    (result_kind),
  .data_byte      (data_byte),
  .byte_index     (byte_index),
  .frame_ok       (frame_ok),
  .payload_length (payload_length),
  .invalid_count  (invalid_count),
  .last_of_run    (last_of_run)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for escaped_frame_decoder_crc16: byte-stuffed frames with CRC-16 check.
// Depends on efd_pkg and the decoder RTL; needs no files or arguments at run time.
module tb;
  import efd_pkg::*;

  localparam int STORE_DEPTH = 64;

  // One result word as the decoder should present it.
  typedef struct {
    logic               kind;
    logic [BYTE_W-1:0]  data;
    logic [IDX_W-1:0]   idx;
    logic               ok;
    logic [IDX_W-1:0]   plen;
    logic [COUNT_W-1:0] count;
    logic               last;
  } frame_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                result_kind;
  logic [BYTE_W-1:0]   data_byte;
  logic [IDX_W-1:0]    byte_index;
  logic                frame_ok;
  logic [IDX_W-1:0]    payload_length;
  logic [COUNT_W-1:0]  invalid_count;
  logic                last_of_run;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [BYTE_W-1:0]   cfg_data = '0;

  // Framing codes as the decoder should hold them; they start at the reset defaults.
  logic [BYTE_W-1:0]   open_code  = START_RESET;
  logic [BYTE_W-1:0]   close_code = END_RESET;
  logic [BYTE_W-1:0]   esc_code   = ESCAPE_RESET;
  logic [BYTE_W-1:0]   esc_mask   = XOR_RESET;

  // Receiver state mirrored by the decode predictor.
  logic                rx_open = 1'b0;
  logic                rx_escaped = 1'b0;
  logic [BYTE_W-1:0]   frame_bytes[$];
  logic [COUNT_W-1:0]  bad_frames_seen = '0;

  logic [BYTE_W-1:0]   wire_bytes[$];     // serial words still to be offered
  frame_word_t         decoded_words[$];  // results owed by the decoder, oldest first
  frame_word_t         head;

  logic                steady = 1'b0;     // set: neither side idles
  int                  fail_count = 0;
  int                  bytes_taken = 0;
  int                  words_checked = 0;
  int                  frame_reports = 0;

  escaped_frame_decoder_crc16 #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .frame_ok      (frame_ok),
    .payload_length(payload_length),
    .invalid_count (invalid_count),
    .last_of_run   (last_of_run),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // CRC-16, polynomial 0x1021, MSB first, over the first n bytes; shifted one bit at a time
  // with the feedback taken from the top bit XOR the incoming data bit.
  function automatic logic [15:0] crc16_ccitt(input logic [BYTE_W-1:0] bytes[$], input int n);
    logic [15:0] c;
    logic        fb;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      for (int k = BYTE_W - 1; k >= 0; k--) begin
        fb = c[15] ^ bytes[i][k];
        c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
    end
    return c;
  endfunction

  // Advance the receiver by one accepted word and queue the result words it owes.
  task automatic receive_byte(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] b;
    int                plen;
    logic              good;
    b = raw;
    plen = 0;
    good = 1'b0;
    if (b == open_code) begin
      // A start word always wins, even right after an escape or inside a frame.
      rx_open = 1'b1;
      rx_escaped = 1'b0;
      frame_bytes.delete();
    end else if (rx_open) begin
      if (b == close_code && !rx_escaped) begin
        rx_open = 1'b0;
        // Fewer than two stored words can never carry a CRC: judge the frame bad.
        if (frame_bytes.size() >= 2) begin
          plen = frame_bytes.size() - 2;
          good = ({frame_bytes[plen], frame_bytes[plen + 1]} == crc16_ccitt(frame_bytes, plen));
        end
        if (!good && bad_frames_seen != COUNT_MAX) bad_frames_seen++;
        if (good) begin
          for (int i = 0; i < plen; i++) begin
            decoded_words.push_back('{KIND_PAYLOAD, frame_bytes[i], IDX_W'(i), 1'b0,
                                      {IDX_W{1'b0}}, bad_frames_seen, 1'b0});
          end
        end
        decoded_words.push_back('{KIND_STATUS, {BYTE_W{1'b0}}, {IDX_W{1'b0}}, good,
                                  good ? IDX_W'(plen) : {IDX_W{1'b0}}, bad_frames_seen, 1'b1});
      end else if (b == esc_code && !rx_escaped) begin
        rx_escaped = 1'b1;
      end else begin
        if (rx_escaped) begin
          b = b ^ esc_mask;
          rx_escaped = 1'b0;
        end
        // A full store drops the whole frame silently and counts it as bad.
        if (frame_bytes.size() < STORE_DEPTH) begin
          frame_bytes.push_back(b);
        end else begin
          rx_open = 1'b0;
          if (bad_frames_seen != COUNT_MAX) bad_frames_seen++;
        end
      end
    end
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: offer the next queued word, hold it until taken, and feed every taken
  // word to the predictor. Idle at random unless the steady stretch is on.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        receive_byte(rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (wire_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 38)) begin
          in_valid <= 1'b1;
          rx_byte  <= wire_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result word with the oldest one owed; stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_words.size() == 0) begin
          $error("result word with nothing owed: kind %0b data 0x%0h", result_kind, data_byte);
          fail_count++;
        end else begin
          head = decoded_words.pop_front();
          check_field("result_kind", 16'(head.kind), 16'(result_kind));
          check_field("data_byte", 16'(head.data), 16'(data_byte));
          check_field("byte_index", 16'(head.idx), 16'(byte_index));
          check_field("frame_ok", 16'(head.ok), 16'(frame_ok));
          check_field("payload_length", 16'(head.plen), 16'(payload_length));
          check_field("invalid_count", head.count, invalid_count);
          check_field("last_of_run", 16'(head.last), 16'(last_of_run));
          words_checked++;
          if (head.kind == KIND_STATUS) frame_reports++;
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  // Write one framing register at the next edge; the caller lowers the strobe.
  task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_START:  open_code  = val;
      REG_END:    close_code = val;
      REG_ESCAPE: esc_code   = val;
      REG_XOR:    esc_mask   = val;
      default:    ;
    endcase
  endtask

  task automatic set_framing(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] m);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_ESCAPE, x);
    write_reg(REG_XOR, m);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Stuff one frame onto the wire: start word, payload and big-endian CRC with
  // collisions escaped, then the end word unless the frame is to be left open.
  // A byte whose escaped form would hit the start code goes out raw and breaks the frame.
  task automatic queue_frame(input logic [BYTE_W-1:0] pl[$], input bit corrupt, input bit closed);
    logic [15:0]       crc;
    logic [BYTE_W-1:0] s;
    crc = crc16_ccitt(pl, pl.size());
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    pl.push_back(crc[15:8]);
    pl.push_back(crc[7:0]);
    wire_bytes.push_back(open_code);
    foreach (pl[i]) begin
      s = pl[i];
      if ((s == open_code || s == close_code || s == esc_code) && (s ^ esc_mask) != open_code)
      begin
        wire_bytes.push_back(esc_code);
        wire_bytes.push_back(s ^ esc_mask);
      end else begin
        wire_bytes.push_back(s);
      end
    end
    if (closed) wire_bytes.push_back(close_code);
  endtask

  // Mostly well-formed frames of small random size, a few near the store limit, plus
  // bad CRCs, frames left open, line noise and store overflows. A first_len of zero
  // or more forces the size of the first frame.
  task automatic queue_traffic(input int budget, input int first_len);
    logic [BYTE_W-1:0] pl[$];
    int                base;
    int                len;
    int                pick;
    int                n;
    base = wire_bytes.size();
    while (wire_bytes.size() - base < budget) begin
      pl.delete();
      pick = $urandom_range(0, 99);
      if (first_len >= 0) begin
        len = first_len;
        first_len = -1;
        pick = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        len = $urandom_range(55, 62);
      end else begin
        len = $urandom_range(0, 10);
      end
      if (pick >= 93) len = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 2);
      repeat (len) pl.push_back(BYTE_W'($urandom));
      if (pick < 68) begin
        queue_frame(pl, 1'b0, 1'b1);
      end else if (pick < 78) begin
        queue_frame(pl, 1'b1, 1'b1);
      end else if (pick < 86) begin
        // Leave the frame open; the next start word restarts it.
        queue_frame(pl, 1'b0, 1'b0);
      end else if (pick < 93) begin
        // Noise between frames is mostly ignored: do not count it.
        n = $urandom_range(1, 4);
        repeat (n) wire_bytes.push_back(BYTE_W'($urandom));
        base += n;
      end else begin
        queue_frame(pl, 1'b0, 1'b1);
      end
    end
  endtask

  // Wait until every word is taken and every owed result has arrived, then give the
  // decoder time to finish work that owes no result (a dropped frame).
  task automatic wait_drained();
    do @(negedge clk);
    while (wire_bytes.size() != 0 || in_valid || decoded_words.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] opening[18];
    logic [BYTE_W-1:0] pl[$];
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] e;
    logic [BYTE_W-1:0] x;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset framing codes.
    opening = '{8'h00, close_code,                       // outside a frame: ignore
                open_code, close_code,                   // empty frame
                open_code, 8'hAB, close_code,            // one stored word: too short
                open_code, 8'hFF, 8'hFF, close_code,     // empty payload, CRC of nothing
                open_code, 8'hFF, 8'hFE, close_code,     // CRC mismatch
                open_code, 8'hAB, esc_code};             // escape left pending
    foreach (opening[i]) wire_bytes.push_back(opening[i]);
    // The start word of this frame lands right after the pending escape and restarts.
    pl.push_back(8'h00);
    pl.push_back(8'hFF);
    pl.push_back(open_code);
    pl.push_back(close_code);
    pl.push_back(esc_code);
    queue_frame(pl, 1'b0, 1'b1);
    wait_drained();

    // Longest good frame the store can hold; neither side idles here.
    steady <= 1'b1;
    queue_traffic(40, STORE_DEPTH - 2);
    wait_drained();
    steady <= 1'b0;

    // Extreme codes, full inversion of escaped words; open with a store overflow.
    set_framing(8'h00, 8'hFF, 8'h80, 8'hFF);
    queue_traffic(40, STORE_DEPTH - 1);
    wait_drained();

    // End code equal to escape code, no XOR; neither side idles here.
    steady <= 1'b1;
    set_framing(8'hFF, 8'h00, 8'h00, 8'h00);
    queue_traffic(10, -1);
    wait_drained();
    steady <= 1'b0;

    // Start, end and escape all the same: every such word restarts, nothing closes.
    set_framing(8'h7E, 8'h7E, 8'h7E, 8'h5A);
    queue_traffic(8, -1);
    wait_drained();

    // Random codes, kept apart from the start code so frames can close.
    s = BYTE_W'($urandom);
    do e = BYTE_W'($urandom); while (e == s);
    do x = BYTE_W'($urandom); while (x == s);
    set_framing(s, e, x, BYTE_W'($urandom));
    queue_traffic(10, -1);
    wait_drained();

    $display("Took %0d serial words under five framing setups; checked %0d result words.",
             bytes_taken, words_checked);
    $display("Frame reports: %0d, bad-frame count ended at %0d.", frame_reports,
             bad_frames_seen);
    if (fail_count == 0) begin
      $display("PASS escaped_frame_decoder_crc16");
    end else begin
      $display("FAIL escaped_frame_decoder_crc16");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAIL escaped_frame_decoder_crc16");
    $finish;
  end

endmodule
